FILE: design/dtp_pkg.sv
`default_nettype none
package dtp_pkg;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOURS_W  = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int ZKIND_W  = 2;
   localparam int ZHOURS_W = 7;
   localparam int OFFSET_W = 13;
   localparam int ACC_W    = 14;
   localparam int DIGIT_W  = 4;
   localparam int POS_W    = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SYNTAX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   localparam logic [ZKIND_W-1:0] ZONE_NONE  = 2'd0;
   localparam logic [ZKIND_W-1:0] ZONE_UTC   = 2'd1;
   localparam logic [ZKIND_W-1:0] ZONE_PLUS  = 2'd2;
   localparam logic [ZKIND_W-1:0] ZONE_MINUS = 2'd3;

   localparam int MONTH_MAX    = 12;
   localparam int DAY_MAX      = 31;
   localparam int HOURS_MAX    = 24;
   localparam int MIN_PER_HOUR = 60;

   typedef enum logic [POS_W-1:0] {
      P_D0, P_D1, P_D2, P_D3, P_DASH1, P_MO0, P_MO1, P_DASH2, P_DY0, P_DY1,
      P_DATE_END, P_H0, P_H1, P_HC, P_MI0, P_MI1, P_MC, P_S0, P_S1,
      P_TIME_END, P_ZH0, P_ZH1, P_ZC, P_ZM0, P_ZM1, P_DONE
   } pos_type;

   typedef struct packed {
      pos_type               pos;
      logic [ACC_W-1:0]      acc;
      logic [STATUS_W-1:0]   err;
      logic [YEAR_W-1:0]     year;
      logic [MONTH_W-1:0]    month;
      logic [DAY_W-1:0]      day;
      logic [HOURS_W-1:0]    hours;
      logic [MIN_W-1:0]      minutes;
      logic [SEC_W-1:0]      seconds;
      logic [ZKIND_W-1:0]    zkind;
      logic [ZHOURS_W-1:0]   zhours;
      logic                  lead24;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      pos: P_D0, acc: '0, err: STATUS_OK, year: '0, month: '0, day: '0,
      hours: '0, minutes: '0, seconds: '0, zkind: ZONE_NONE, zhours: '0,
      lead24: 1'b0
   };

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOURS_W-1:0]  hours;
      logic [MIN_W-1:0]    minutes;
      logic [SEC_W-1:0]    seconds;
      logic [ZKIND_W-1:0]  zone_kind;
      logic [OFFSET_W-1:0] zone_offset;
   } result_type;

endpackage
`default_nettype wire

FILE: design/dtp_step.sv
`default_nettype none
module dtp_step (
   input  wire dtp_pkg::parse_state_type      cur,
   input  wire logic [dtp_pkg::CHAR_W-1:0]    char_code,
   output dtp_pkg::parse_state_type           nxt
);

   logic                          dig;
   logic [dtp_pkg::DIGIT_W-1:0]   d;
   logic [dtp_pkg::ACC_W-1:0]     v;

   assign dig = (char_code >= dtp_pkg::CHAR_ZERO) && (char_code <= dtp_pkg::CHAR_NINE);
   assign d   = dig ? dtp_pkg::DIGIT_W'(char_code - dtp_pkg::CHAR_ZERO) : '0;
   assign v   = dtp_pkg::ACC_W'(17'({cur.acc, 3'b000}) + 17'({cur.acc, 1'b0}) + 17'(d));

   function automatic dtp_pkg::parse_state_type zone_start(
      input dtp_pkg::parse_state_type s,
      input logic [dtp_pkg::CHAR_W-1:0] c
   );
      dtp_pkg::parse_state_type r;
      r = s;
      if (c == dtp_pkg::CHAR_Z) begin
         r.zkind  = dtp_pkg::ZONE_UTC;
         r.zhours = '0;
         r.acc    = '0;
         r.pos    = dtp_pkg::P_DONE;
      end else if (c == dtp_pkg::CHAR_PLUS || c == dtp_pkg::CHAR_DASH) begin
         r.zkind = (c == dtp_pkg::CHAR_PLUS) ? dtp_pkg::ZONE_PLUS : dtp_pkg::ZONE_MINUS;
         r.pos   = dtp_pkg::P_ZH0;
      end else begin
         r.err = dtp_pkg::STATUS_SYNTAX;
      end
      return r;
   endfunction

   function automatic logic [dtp_pkg::STATUS_W-1:0] date_fail(input logic lead);
      return lead ? dtp_pkg::STATUS_RANGE : dtp_pkg::STATUS_SYNTAX;
   endfunction

   always_comb begin
      nxt = cur;
      if (cur.err == dtp_pkg::STATUS_OK) begin
         case (cur.pos)
            dtp_pkg::P_D0: begin
               if (dig) begin
                  nxt.acc = dtp_pkg::ACC_W'(d);
                  nxt.pos = dtp_pkg::P_D1;
               end else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            dtp_pkg::P_D1: begin
               if (dig) begin
                  nxt.acc    = v;
                  nxt.lead24 = (v > dtp_pkg::ACC_W'(dtp_pkg::HOURS_MAX));
                  nxt.pos    = dtp_pkg::P_D2;
               end else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            dtp_pkg::P_D2: begin
               if (dig) begin
                  nxt.acc = v;
                  nxt.pos = dtp_pkg::P_D3;
               end else if (char_code == dtp_pkg::CHAR_COLON) begin
                  if (cur.lead24) nxt.err = dtp_pkg::STATUS_RANGE;
                  else begin
                     nxt.hours = dtp_pkg::HOURS_W'(cur.acc);
                     nxt.pos   = dtp_pkg::P_MI0;
                  end
               end else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_D3: begin
               if (dig) begin
                  nxt.year = dtp_pkg::YEAR_W'(v);
                  nxt.pos  = dtp_pkg::P_DASH1;
               end else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_DASH1: begin
               if (char_code == dtp_pkg::CHAR_DASH) nxt.pos = dtp_pkg::P_MO0;
               else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_DASH2: begin
               if (char_code == dtp_pkg::CHAR_DASH) nxt.pos = dtp_pkg::P_DY0;
               else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_MO0: begin
               if (dig) begin
                  nxt.acc = dtp_pkg::ACC_W'(d);
                  nxt.pos = dtp_pkg::P_MO1;
               end else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_DY0: begin
               if (dig) begin
                  nxt.acc = dtp_pkg::ACC_W'(d);
                  nxt.pos = dtp_pkg::P_DY1;
               end else nxt.err = date_fail(cur.lead24);
            end
            dtp_pkg::P_MO1: begin
               if (!dig) nxt.err = date_fail(cur.lead24);
               else if (v < dtp_pkg::ACC_W'(1) || v > dtp_pkg::ACC_W'(dtp_pkg::MONTH_MAX))
                  nxt.err = dtp_pkg::STATUS_RANGE;
               else begin
                  nxt.month = dtp_pkg::MONTH_W'(v);
                  nxt.pos   = dtp_pkg::P_DASH2;
               end
            end
            dtp_pkg::P_DY1: begin
               if (!dig) nxt.err = date_fail(cur.lead24);
               else if (v < dtp_pkg::ACC_W'(1) || v > dtp_pkg::ACC_W'(dtp_pkg::DAY_MAX))
                  nxt.err = dtp_pkg::STATUS_RANGE;
               else begin
                  nxt.day = dtp_pkg::DAY_W'(v);
                  nxt.pos = dtp_pkg::P_DATE_END;
               end
            end
            dtp_pkg::P_DATE_END: begin
               if (char_code == dtp_pkg::CHAR_T) nxt.pos = dtp_pkg::P_H0;
               else nxt = zone_start(cur, char_code);
            end
            dtp_pkg::P_H0, dtp_pkg::P_MI0, dtp_pkg::P_S0, dtp_pkg::P_ZH0,
            dtp_pkg::P_ZM0: begin
               if (dig) begin
                  nxt.acc = dtp_pkg::ACC_W'(d);
                  nxt.pos = dtp_pkg::pos_type'(cur.pos + dtp_pkg::POS_W'(1));
               end else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            dtp_pkg::P_H1: begin
               if (!dig) nxt.err = dtp_pkg::STATUS_SYNTAX;
               else if (v > dtp_pkg::ACC_W'(dtp_pkg::HOURS_MAX)) nxt.err = dtp_pkg::STATUS_RANGE;
               else begin
                  nxt.hours = dtp_pkg::HOURS_W'(v);
                  nxt.pos   = dtp_pkg::P_HC;
               end
            end
            dtp_pkg::P_MI1: begin
               if (!dig) nxt.err = dtp_pkg::STATUS_SYNTAX;
               else if (v >= dtp_pkg::ACC_W'(dtp_pkg::MIN_PER_HOUR))
                  nxt.err = dtp_pkg::STATUS_RANGE;
               else begin
                  nxt.minutes = dtp_pkg::MIN_W'(v);
                  nxt.pos     = dtp_pkg::P_MC;
               end
            end
            dtp_pkg::P_S1: begin
               if (!dig) nxt.err = dtp_pkg::STATUS_SYNTAX;
               else if (v >= dtp_pkg::ACC_W'(dtp_pkg::MIN_PER_HOUR))
                  nxt.err = dtp_pkg::STATUS_RANGE;
               else begin
                  nxt.seconds = dtp_pkg::SEC_W'(v);
                  nxt.pos     = dtp_pkg::P_TIME_END;
               end
            end
            dtp_pkg::P_HC, dtp_pkg::P_MC, dtp_pkg::P_ZC: begin
               if (char_code == dtp_pkg::CHAR_COLON)
                  nxt.pos = dtp_pkg::pos_type'(cur.pos + dtp_pkg::POS_W'(1));
               else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            dtp_pkg::P_TIME_END: begin
               nxt = zone_start(cur, char_code);
            end
            dtp_pkg::P_ZH1: begin
               if (dig) begin
                  nxt.zhours = dtp_pkg::ZHOURS_W'(v);
                  nxt.pos    = dtp_pkg::P_ZC;
               end else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            dtp_pkg::P_ZM1: begin
               if (dig) begin
                  nxt.acc = v;
                  nxt.pos = dtp_pkg::P_DONE;
               end else nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
            default: begin
               nxt.err = dtp_pkg::STATUS_SYNTAX;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: design/dtp_result.sv
`default_nettype none
module dtp_result (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dtp_pkg::parse_state_type  fin,
   input  wire logic                      load,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic                           room,
   output dtp_pkg::result_type            rsp
);

   dtp_pkg::result_type             res_ff, res_in;
   logic                            valid_ff, valid_in;
   logic [dtp_pkg::STATUS_W-1:0]    stat;
   logic                            complete;
   logic                            in_date;

   assign complete = (fin.pos == dtp_pkg::P_DATE_END) || (fin.pos == dtp_pkg::P_TIME_END) ||
                     (fin.pos == dtp_pkg::P_DONE);
   assign in_date  = (fin.pos >= dtp_pkg::P_D2) && (fin.pos <= dtp_pkg::P_DY1);

   always_comb begin
      stat = fin.err;
      if (stat == dtp_pkg::STATUS_OK && !complete)
         stat = (in_date && fin.lead24) ? dtp_pkg::STATUS_RANGE : dtp_pkg::STATUS_SYNTAX;
      res_in        = '0;
      res_in.status = stat;
      if (stat == dtp_pkg::STATUS_OK) begin
         res_in.year      = fin.year;
         res_in.month     = fin.month;
         res_in.day       = fin.day;
         res_in.hours     = fin.hours;
         res_in.minutes   = fin.minutes;
         res_in.seconds   = fin.seconds;
         res_in.zone_kind = fin.zkind;
         if (fin.zkind == dtp_pkg::ZONE_PLUS || fin.zkind == dtp_pkg::ZONE_MINUS)
            res_in.zone_offset = dtp_pkg::OFFSET_W'(
               dtp_pkg::OFFSET_W'(fin.zhours) * dtp_pkg::OFFSET_W'(dtp_pkg::MIN_PER_HOUR) +
               dtp_pkg::OFFSET_W'(fin.acc));
      end
   end

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule
`default_nettype wire

FILE: design/iso_datetime_text_parser_unit.sv
`default_nettype none
// Parses ISO style date/time text (YYYY-MM-DD, hh:mm:ss or both joined by T,
// optionally followed by Z or +hh:mm / -hh:mm) fed one ASCII character per
// transaction, with req_is_last marking the final character. One character
// is taken every cycle; a character is held in the input register and folded
// into the parse state or, for the final character, into the result register
// that presents the result. The final character of a string stalls only
// while the result register still holds an untaken result.
// Status 0 ok, 1 syntax error or trailing text, 2 field out of range; on an
// error every other result field is 0. Parse state returns to the start
// after each final character.
module iso_datetime_text_parser_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dtp_pkg::CHAR_W-1:0]            req_char_code,
   input  wire logic                                  req_is_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [dtp_pkg::STATUS_W-1:0]               rsp_status,
   output logic [dtp_pkg::YEAR_W-1:0]                 rsp_year,
   output logic [dtp_pkg::MONTH_W-1:0]                rsp_month,
   output logic [dtp_pkg::DAY_W-1:0]                  rsp_day,
   output logic [dtp_pkg::HOURS_W-1:0]                rsp_hours,
   output logic [dtp_pkg::MIN_W-1:0]                  rsp_minutes,
   output logic [dtp_pkg::SEC_W-1:0]                  rsp_seconds,
   output logic [dtp_pkg::ZKIND_W-1:0]                rsp_zone_kind,
   output logic [dtp_pkg::OFFSET_W-1:0]               rsp_zone_offset_minutes
);

   logic                           in_valid_ff, in_valid_in;
   logic [dtp_pkg::CHAR_W-1:0]     in_char_ff;
   logic                           in_last_ff;
   dtp_pkg::parse_state_type       state_ff, state_in;
   dtp_pkg::parse_state_type       nxt;
   dtp_pkg::result_type            rsp;
   logic                           room;
   logic                           advance;

   assign advance     = in_valid_ff && (!in_last_ff || room);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign state_in    = advance ? (in_last_ff ? dtp_pkg::PARSE_RESET : nxt) : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= dtp_pkg::PARSE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_is_last;
      end
   end

   dtp_step u_step (
      .cur       (state_ff),
      .char_code (in_char_ff),
      .nxt       (nxt)
   );

   dtp_result u_result (
      .clock     (clock),
      .reset     (reset),
      .fin       (nxt),
      .load      (advance && in_last_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .room      (room),
      .rsp       (rsp)
   );

   assign rsp_status              = rsp.status;
   assign rsp_year                = rsp.year;
   assign rsp_month               = rsp.month;
   assign rsp_day                 = rsp.day;
   assign rsp_hours               = rsp.hours;
   assign rsp_minutes             = rsp.minutes;
   assign rsp_seconds             = rsp.seconds;
   assign rsp_zone_kind           = rsp.zone_kind;
   assign rsp_zone_offset_minutes = rsp.zone_offset;

endmodule
`default_nettype wire

FILE: design/dtp_checker.sv
`default_nettype none
module dtp_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_ready,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [dtp_pkg::STATUS_W-1:0]          rsp_status,
   input wire logic [dtp_pkg::YEAR_W-1:0]            rsp_year,
   input wire logic [dtp_pkg::MONTH_W-1:0]           rsp_month,
   input wire logic [dtp_pkg::DAY_W-1:0]             rsp_day,
   input wire logic [dtp_pkg::HOURS_W-1:0]           rsp_hours,
   input wire logic [dtp_pkg::MIN_W-1:0]             rsp_minutes,
   input wire logic [dtp_pkg::SEC_W-1:0]             rsp_seconds,
   input wire logic [dtp_pkg::ZKIND_W-1:0]           rsp_zone_kind,
   input wire logic [dtp_pkg::OFFSET_W-1:0]          rsp_zone_offset_minutes
);

   logic rsp_zero;

   assign rsp_zero = (rsp_year == '0) && (rsp_month == '0) && (rsp_day == '0) &&
                     (rsp_hours == '0) && (rsp_minutes == '0) && (rsp_seconds == '0) &&
                     (rsp_zone_kind == '0) && (rsp_zone_offset_minutes == '0);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pending transaction after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_year) &&
      $stable(rsp_zone_offset_minutes))
      else $error("stalled result changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dtp_pkg::STATUS_OK |-> rsp_zero)
      else $error("error result carries field data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == dtp_pkg::STATUS_OK || rsp_status == dtp_pkg::STATUS_SYNTAX ||
      rsp_status == dtp_pkg::STATUS_RANGE)
      else $error("undefined status code");

   a_offset_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_zone_kind == dtp_pkg::ZONE_NONE || rsp_zone_kind == dtp_pkg::ZONE_UTC)
      |-> rsp_zone_offset_minutes == '0)
      else $error("offset without signed zone");

endmodule

bind iso_datetime_text_parser_unit dtp_checker u_checker (.*);
`default_nettype wire
